// File: src/prwt_pkg.sv
// Package: shared types, constants and the helper function of the receive window tracker.
`default_nettype none

package prwt_pkg;

  localparam int unsigned RPC_SLOTS_DEF     = 1024;
  localparam int unsigned PAYLOAD_BYTES_DEF = 1024;

  // Window size in packets; bit 63 of the map is the packet at head.
  localparam int unsigned WIN   = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;

  localparam int unsigned ID_W  = 10;
  localparam int unsigned OFF_W = 32;
  localparam int unsigned LEN_W = 32;

  // One slot entry of the window memory.
  typedef struct packed {
    logic [WIN-1:0]   bits;
    logic [OFF_W-1:0] head;
    logic [LEN_W-1:0] len;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic [ID_W-1:0]  slot;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             init;
    logic             complete;
  } res_t;

  // Memory port strobes.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

  // Count the run of ones starting at the top bit (64 when all ones).
  function automatic logic [CNT_W-1:0] lead_ones(logic [WIN-1:0] m);
    logic [CNT_W-1:0] n;
    logic             hit;
    n   = CNT_W'(WIN);
    hit = 1'b0;
    for (int i = 0; i < WIN; i++) begin
      if (!hit && !m[WIN-1-i]) begin
        n   = CNT_W'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/packet_receive_window_tracker_top.sv
// Top level: receive window tracker with window memory and output register.
//
// Usage: each input beat is one data packet header (pkt_slot_i, pkt_offset_i,
// pkt_msg_len_i) on a valid/ready channel. For every header that lands in
// its slot's 64-packet window and is not a duplicate, one result beat leaves
// on the output valid/ready channel carrying the header, an init flag (the
// packet opened the slot) and a complete flag (head reached message length).
// Other headers are dropped without a result.
// Sequence: an accepted header runs the slot read-modify-write sequence (read,
// divide, update, write back) on the single window memory, and its result then
// enters the output register; no new header is taken until it is through.
// A header that misses its window or repeats a packet frees the input after
// the update step. A header whose pkt_slot_i is at or above RPC_SLOTS is
// dropped in its accept cycle and the next one may follow directly.
// Reset: after rst_ni releases, a clearing pass writes every slot, one per
// cycle, for RPC_SLOTS cycles; in_ready_o stays low until it finishes.
// Stall: the output register holds a result until it is taken; a following
// header still runs up to write back and then waits there, so the next
// result is never lost and the slot is not written until it can be issued.
`default_nettype none

module packet_receive_window_tracker_top #(
  parameter int unsigned RPC_SLOTS     = prwt_pkg::RPC_SLOTS_DEF,
  parameter int unsigned PAYLOAD_BYTES = prwt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [prwt_pkg::ID_W-1:0]   pkt_slot_i,
  input  wire logic [prwt_pkg::OFF_W-1:0]  pkt_offset_i,
  input  wire logic [prwt_pkg::LEN_W-1:0]  pkt_msg_len_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [prwt_pkg::ID_W-1:0]        slot_out_o,
  output logic [prwt_pkg::OFF_W-1:0]       offset_out_o,
  output logic [prwt_pkg::LEN_W-1:0]       length_out_o,
  output logic                             init_flag_o,
  output logic                             complete_flag_o
);
  import prwt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(RPC_SLOTS);

  mem_req_t          mem_req;
  logic [SLOT_W-1:0] mem_rd_addr;
  logic [SLOT_W-1:0] mem_wr_addr;
  entry_t            mem_wr_data;
  entry_t            mem_rd_data;

  logic              res_valid;
  logic              res_ready;
  res_t              res;

  logic              out_valid_q;
  res_t              out_q;

  prwt_mem #(
    .DEPTH  (RPC_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  prwt_core #(
    .RPC_SLOTS     (RPC_SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .SLOT_W        (SLOT_W)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pkt_slot_i       (pkt_slot_i),
    .pkt_offset_i     (pkt_offset_i),
    .pkt_msg_len_i    (pkt_msg_len_i),
    .res_ready_i      (res_ready),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .mem_req_o        (mem_req),
    .mem_rd_addr_o    (mem_rd_addr),
    .mem_wr_addr_o    (mem_wr_addr),
    .mem_wr_data_o    (mem_wr_data),
    .mem_rd_data_i    (mem_rd_data)
  );

  // Output register: take a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while the beat waits.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_out_o      = out_q.slot;
  assign offset_out_o    = out_q.offset;
  assign length_out_o    = out_q.length;
  assign init_flag_o     = out_q.init;
  assign complete_flag_o = out_q.complete;

endmodule

`default_nettype wire

// File: src/prwt_mem.sv
// Window memory: one entry per slot, one write port, one registered read port.
`default_nettype none

module prwt_mem #(
  parameter int unsigned DEPTH  = prwt_pkg::RPC_SLOTS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire prwt_pkg::mem_req_t  req_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire prwt_pkg::entry_t    wr_data_i,
  output prwt_pkg::entry_t         rd_data_o
);
  import prwt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/prwt_core.sv
// Sequencer and datapath: clear sweep, slot read, index divide, window update, write back.
`default_nettype none

module prwt_core #(
  parameter int unsigned RPC_SLOTS     = prwt_pkg::RPC_SLOTS_DEF,
  parameter int unsigned PAYLOAD_BYTES = prwt_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned SLOT_W        = $clog2(RPC_SLOTS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [prwt_pkg::ID_W-1:0]      pkt_slot_i,
  input  wire logic [prwt_pkg::OFF_W-1:0]     pkt_offset_i,
  input  wire logic [prwt_pkg::LEN_W-1:0]     pkt_msg_len_i,
  input  wire logic                           res_ready_i,
  output logic                                res_valid_o,
  output prwt_pkg::res_t                      res_o,
  output prwt_pkg::mem_req_t                  mem_req_o,
  output logic [SLOT_W-1:0]                   mem_rd_addr_o,
  output logic [SLOT_W-1:0]                   mem_wr_addr_o,
  output prwt_pkg::entry_t                    mem_wr_data_o,
  input  wire prwt_pkg::entry_t               mem_rd_data_i
);
  import prwt_pkg::*;

  // Offset differences inside the window fit in DIFF_W bits. The quotient by
  // PAYLOAD_BYTES is a multiply by a rounded-up reciprocal; with RECIP_S chosen
  // this way the rounding error never reaches the next integer.
  localparam logic [OFF_W-1:0] WIN_SPAN = OFF_W'(WIN * PAYLOAD_BYTES);
  localparam int unsigned DIFF_W  = $clog2(WIN * PAYLOAD_BYTES);
  localparam int unsigned RECIP_S = DIFF_W + $clog2(PAYLOAD_BYTES);
  localparam int unsigned PROD_W  = RECIP_S + IDX_W;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_S) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_WB    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;

  logic [SLOT_W-1:0] addr_q;
  logic [ID_W-1:0]   slot_q;
  logic [OFF_W-1:0]  off_q;
  logic [LEN_W-1:0]  mlen_q;
  logic [WIN-1:0]    bits_q;
  logic [OFF_W-1:0]  head_q;
  logic [LEN_W-1:0]  len_q;
  logic              init_q;
  logic [OFF_W-1:0]  diff_q;
  logic [IDX_W-1:0]  q_q;
  logic              win_q;
  logic [CNT_W-1:0]  shift_q;

  logic              accept;
  logic              in_range;
  logic              fresh;
  logic [OFF_W-1:0]  head_sel;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  bpos;
  logic              dup;
  logic [WIN-1:0]    bits_set;
  logic [OFF_W-1:0]  head_new;
  logic [WIN-1:0]    bits_new;
  logic              wb_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (OFF_W'(pkt_slot_i) < OFF_W'(RPC_SLOTS));

  // Fresh slot: stored length of zero opens an empty window at head zero.
  assign fresh    = (mem_rd_data_i.len == '0);
  assign head_sel = fresh ? '0 : mem_rd_data_i.head;

  assign prod = PROD_W'(diff_q[DIFF_W-1:0]) * PROD_W'(RECIP_M);

  // Index 0 sits at the top bit of the map.
  assign bpos     = ~q_q;
  assign dup      = bits_q[bpos];
  assign bits_set = bits_q | (WIN'(1) << bpos);

  assign head_new = head_q + OFF_W'(OFF_W'(shift_q) * OFF_W'(PAYLOAD_BYTES));
  assign bits_new = shift_q[CNT_W-1] ? '0 : (bits_q << shift_q[IDX_W-1:0]);
  assign wb_go    = (state_q == ST_WB) && res_ready_i;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(RPC_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_DIV;
      ST_DIV:  state_d = ST_UPD;
      ST_UPD: begin
        state_d = (win_q && !dup) ? ST_WB : ST_IDLE;
      end
      ST_WB: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_q <= SLOT_W'(pkt_slot_i);
          slot_q <= pkt_slot_i;
          off_q  <= pkt_offset_i;
          mlen_q <= pkt_msg_len_i;
        end
      end
      ST_READ: begin
        bits_q <= fresh ? '0 : mem_rd_data_i.bits;
        head_q <= head_sel;
        len_q  <= fresh ? mlen_q : mem_rd_data_i.len;
        init_q <= fresh;
        diff_q <= off_q - head_sel;
      end
      ST_DIV: begin
        q_q   <= prod[RECIP_S +: IDX_W];
        win_q <= (diff_q < WIN_SPAN);
      end
      ST_UPD: begin
        bits_q  <= bits_set;
        shift_q <= lead_ones(bits_set);
      end
      default: begin
      end
    endcase
  end

  // Memory port: the clear sweep and write back share the write side.
  always_comb begin
    mem_req_o.rd_en = accept && in_range;
    mem_req_o.wr_en = (state_q == ST_CLEAR) || wb_go;
    mem_rd_addr_o   = SLOT_W'(pkt_slot_i);
    mem_wr_addr_o   = (state_q == ST_CLEAR) ? clr_q : addr_q;
    if (state_q == ST_CLEAR) begin
      mem_wr_data_o = '0;
    end else begin
      mem_wr_data_o.bits = bits_new;
      mem_wr_data_o.head = head_new;
      mem_wr_data_o.len  = len_q;
    end
  end

  assign res_valid_o     = wb_go;
  assign res_o.slot      = slot_q;
  assign res_o.offset    = off_q;
  assign res_o.length    = mlen_q;
  assign res_o.init      = init_q;
  assign res_o.complete  = (head_new >= len_q);

  a_res_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_ready_i)
    else $error("result issued while output register is full");

  a_wr_only_clear_or_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (state_q == ST_CLEAR || state_q == ST_WB))
    else $error("memory write outside clear sweep or write back");

  a_read_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range) |=> (state_q == ST_READ))
    else $error("slot read not started after accepted beat");

  a_wb_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == ST_UPD || $past(state_q) == ST_WB))
    else $error("result without a window update");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !mem_req_o.rd_en)
    else $error("slot read during clear sweep");

endmodule

`default_nettype wire
